[rtl/eqps_pkg.sv]
`default_nettype none
package eqps_pkg;

   typedef enum logic [2:0] {
      REQ_REGISTER  = 3'd0,
      REQ_POST      = 3'd1,
      REQ_BROADCAST = 3'd2,
      REQ_SET_READY = 3'd3,
      REQ_START     = 3'd4,
      REQ_SCHEDULE  = 3'd5,
      REQ_REPORT    = 3'd6,
      REQ_UNUSED    = 3'd7
   } req_kind_type;

   typedef enum logic [3:0] {
      K_ACCEPTED = 4'd0,
      K_DROPPED  = 4'd1,
      K_FULL     = 4'd2,
      K_DISPATCH = 4'd3,
      K_DUMMY    = 4'd4,
      K_INIT     = 4'd5,
      K_IDLE     = 4'd6,
      K_FAULT    = 4'd7,
      K_TIME_OK  = 4'd8
   } result_kind_type;

   localparam logic [0:0] CSR_SCHED_MODE    = 1'd0;
   localparam logic [0:0] CSR_TIMEOUT_LIMIT = 1'd1;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd5;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  dest_id;
      logic [7:0]  signal_code;
      logic [31:0] payload_word;
      logic [31:0] elapsed_ticks;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  result_kind;
      logic [2:0]  out_target;
      logic [7:0]  out_signal;
      logic [31:0] out_payload;
      logic        is_last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_SWEEP,
      ST_READ,
      ST_EMIT,
      ST_WAIT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic clear_idx;
      logic step_idx;
      logic do_single;
      logic do_sweep;
      logic do_read;
      logic emit;
      logic emit_idle;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     single_op;
      logic     sweep_op;
      logic     idx_last;
      logic     idx_hit;
      logic     need_read;
      logic     any_emitted;
      logic     rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/event_queue_priority_scheduler.sv]
`default_nettype none
// Event dispatcher for up to eight targets with a ring queue each. One request
// is worked at a time. Broadcast, start and queue-mode schedule sweep the
// targets one per cycle while no event is dispatched and rsp_ready does not
// stall; each dispatched event goes through the event store read port.
// Event storage is not cleared after reset; queue counts are.
module event_queue_priority_scheduler #(
   parameter int TARGET_COUNT = 8,
   parameter int QUEUE_DEPTH  = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire eqps_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output eqps_pkg::rsp_word_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [31:0]            csr_data
);

   eqps_pkg::dp_cmd_type    cmd;
   eqps_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   eqps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   eqps_datapath #(
      .TARGET_COUNT (TARGET_COUNT),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule
`default_nettype wire

[rtl/eqps_ctrl.sv]
`default_nettype none
module eqps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire eqps_pkg::dp_status_type status,
   output eqps_pkg::dp_cmd_type         cmd
);

   eqps_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eqps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         eqps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.clear_idx = 1'b1;
               state_in      = eqps_pkg::ST_SINGLE;
            end
         end
         eqps_pkg::ST_SINGLE: begin
            // single-result requests and the sweep dispatch
            if (status.single_op) begin
               if (status.need_read) begin
                  cmd.do_read = 1'b1;
                  state_in    = eqps_pkg::ST_READ;
               end else if (status.rsp_free) begin
                  cmd.do_single = 1'b1;
                  state_in      = eqps_pkg::ST_IDLE;
               end
            end else begin
               state_in = eqps_pkg::ST_SWEEP;
            end
         end
         eqps_pkg::ST_SWEEP: begin
            // one target per cycle unless a read or a busy output holds it
            if (status.idx_hit && status.need_read) begin
               cmd.do_read = 1'b1;
               state_in    = eqps_pkg::ST_READ;
            end else if (status.idx_hit) begin
               if (status.rsp_free) begin
                  cmd.do_sweep = 1'b1;
                  cmd.step_idx = 1'b1;
                  if (status.idx_last) begin
                     state_in = eqps_pkg::ST_WAIT;
                  end
               end
            end else begin
               cmd.step_idx = 1'b1;
               if (status.idx_last) begin
                  state_in = eqps_pkg::ST_WAIT;
               end
            end
         end
         eqps_pkg::ST_READ: begin
            state_in = eqps_pkg::ST_EMIT;
         end
         eqps_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.sweep_op && !status.idx_last) begin
                  cmd.step_idx = 1'b1;
                  state_in     = eqps_pkg::ST_SWEEP;
               end else if (status.sweep_op) begin
                  cmd.step_idx = 1'b1;
                  state_in     = eqps_pkg::ST_WAIT;
               end else begin
                  state_in = eqps_pkg::ST_IDLE;
               end
            end
         end
         eqps_pkg::ST_WAIT: begin
            // closing result: last flag already set, else emit idle
            if (status.any_emitted) begin
               cmd.emit_idle = 1'b0;
               state_in      = eqps_pkg::ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.emit_idle = 1'b1;
               state_in      = eqps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eqps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/eqps_datapath.sv]
`default_nettype none
module eqps_datapath #(
   parameter int TARGET_COUNT = 8,
   parameter int QUEUE_DEPTH  = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire eqps_pkg::req_word_type  req_data,
   input  wire logic                    csr_valid,
   input  wire logic                    csr_index,
   input  wire logic [31:0]             csr_data,
   input  wire eqps_pkg::dp_cmd_type    cmd,
   output eqps_pkg::dp_status_type      status,
   output logic                         rsp_valid,
   output eqps_pkg::rsp_word_type       rsp_data,
   input  wire logic                    rsp_ready
);

   localparam int TW = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MD = TARGET_COUNT * QUEUE_DEPTH;
   localparam int AW = TW + QW;
   localparam int EW = 8 + PAYLOAD_BITS;
   localparam int IW = TW + 1;

   // configuration
   logic        mode_ff;
   logic [31:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         limit_ff <= eqps_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         if (csr_index == eqps_pkg::CSR_SCHED_MODE) begin
            mode_ff <= csr_data[0];
         end else begin
            limit_ff <= csr_data;
         end
      end
   end

   // latched request
   eqps_pkg::req_word_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   eqps_pkg::req_kind_type kind;
   assign kind = eqps_pkg::req_kind_type'(req_ff.req_type);

   logic [TARGET_COUNT-1:0] reg_ff, rdy_ff;
   logic [QW-1:0]           head_ff [TARGET_COUNT];
   logic [CW-1:0]           cnt_ff  [TARGET_COUNT];
   logic [EW-1:0]           mem     [MD];
   logic [EW-1:0]           rd_ff;
   logic [IW-1:0]           idx_ff;
   logic                    emitted_ff;
   logic                    busy_sweep_ff;

   // request target in range
   logic        tgt_ok;
   logic [TW-1:0] tgt;
   assign tgt_ok = ({29'd0, req_ff.dest_id} < 32'(TARGET_COUNT));
   assign tgt    = TW'(req_ff.dest_id);

   // bitmap top pick
   logic          top_found;
   logic [TW-1:0] top;
   always_comb begin
      top_found = 1'b0;
      top       = '0;
      for (int i = 0; i < TARGET_COUNT; i++) begin
         if (rdy_ff[i]) begin
            top_found = 1'b1;
            top       = TW'(i);
         end
      end
   end

   logic [TW-1:0] cur;
   assign cur = idx_ff[TW-1:0];

   logic single_op, sweep_op;
   assign sweep_op  = (kind == eqps_pkg::REQ_BROADCAST) || (kind == eqps_pkg::REQ_START) ||
                      ((kind == eqps_pkg::REQ_SCHEDULE) && !mode_ff);
   assign single_op = !sweep_op;

   logic st_deq;
   assign st_deq = (kind == eqps_pkg::REQ_SCHEDULE) && top_found && reg_ff[top] &&
                   (cnt_ff[top] != '0);

   logic sw_hit;
   always_comb begin
      sw_hit = reg_ff[cur];
      if (kind == eqps_pkg::REQ_SCHEDULE) begin
         sw_hit = reg_ff[cur] && (cnt_ff[cur] != '0);
      end
   end

   // any sweep target above the current one still to give a result
   logic more_above;
   always_comb begin
      logic hit;
      more_above = 1'b0;
      for (int i = 0; i < TARGET_COUNT; i++) begin
         hit = reg_ff[i];
         if (kind == eqps_pkg::REQ_SCHEDULE) begin
            hit = reg_ff[i] && (cnt_ff[i] != '0);
         end
         if (hit && (IW'(i) > idx_ff)) begin
            more_above = 1'b1;
         end
      end
   end

   assign status.single_op   = single_op;
   assign status.sweep_op    = busy_sweep_ff;
   assign status.idx_last    = (idx_ff == IW'(TARGET_COUNT - 1));
   assign status.idx_hit     = sw_hit;
   assign status.need_read   = single_op ? st_deq : (kind == eqps_pkg::REQ_SCHEDULE);
   assign status.any_emitted = emitted_ff;
   assign status.rsp_free    = !rsp_valid || rsp_ready;

   // single-result word
   eqps_pkg::rsp_word_type single_w;
   always_comb begin
      single_w = '0;
      single_w.out_target = req_ff.dest_id;
      single_w.is_last    = 1'b1;
      single_w.result_kind = eqps_pkg::K_DROPPED;
      unique case (kind)
         eqps_pkg::REQ_REGISTER, eqps_pkg::REQ_SET_READY: begin
            if (tgt_ok) single_w.result_kind = eqps_pkg::K_ACCEPTED;
         end
         eqps_pkg::REQ_POST: begin
            if (tgt_ok && reg_ff[tgt]) begin
               single_w.result_kind = (cnt_ff[tgt] >= CW'(QUEUE_DEPTH)) ?
                                      eqps_pkg::K_FULL : eqps_pkg::K_ACCEPTED;
            end
         end
         eqps_pkg::REQ_REPORT: begin
            single_w.result_kind = (req_ff.elapsed_ticks > limit_ff) ?
                                   eqps_pkg::K_FAULT : eqps_pkg::K_TIME_OK;
            single_w.out_payload = req_ff.elapsed_ticks;
         end
         eqps_pkg::REQ_SCHEDULE: begin
            single_w.out_target = 3'(top);
            if (!top_found) begin
               single_w.result_kind = eqps_pkg::K_IDLE;
               single_w.out_target  = '0;
            end else if (reg_ff[top]) begin
               single_w.result_kind = eqps_pkg::K_DUMMY;
            end
         end
         default: begin
            single_w.result_kind = eqps_pkg::K_DROPPED;
         end
      endcase
   end

   // sweep result word without last flag
   eqps_pkg::rsp_word_type sweep_w;
   always_comb begin
      sweep_w = '0;
      sweep_w.out_target = 3'(cur);
      if (kind == eqps_pkg::REQ_START) begin
         sweep_w.result_kind = eqps_pkg::K_INIT;
      end else begin
         sweep_w.result_kind = (cnt_ff[cur] >= CW'(QUEUE_DEPTH)) ?
                               eqps_pkg::K_FULL : eqps_pkg::K_ACCEPTED;
      end
   end

   // enqueue write address, ring wrap by compare and subtract
   logic [AW-1:0] wr_addr_s, wr_addr_b, rd_addr;
   logic [QW-1:0] tail_s, tail_b;
   logic [QW:0]   sum_s, sum_b;
   assign sum_s     = (QW+1)'(head_ff[tgt]) + (QW+1)'(cnt_ff[tgt]);
   assign sum_b     = (QW+1)'(head_ff[cur]) + (QW+1)'(cnt_ff[cur]);
   assign tail_s    = (sum_s >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(sum_s - (QW+1)'(QUEUE_DEPTH)) : QW'(sum_s);
   assign tail_b    = (sum_b >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(sum_b - (QW+1)'(QUEUE_DEPTH)) : QW'(sum_b);
   assign wr_addr_s = AW'(32'(tgt) * QUEUE_DEPTH + 32'(tail_s));
   assign wr_addr_b = AW'(32'(cur) * QUEUE_DEPTH + 32'(tail_b));
   logic [TW-1:0] rd_t;
   assign rd_t    = single_op ? top : cur;
   assign rd_addr = AW'(32'(rd_t) * QUEUE_DEPTH + 32'(head_ff[rd_t]));

   logic [EW-1:0] new_ev;
   assign new_ev = {req_ff.signal_code, PAYLOAD_BITS'(req_ff.payload_word)};

   logic post_wr, bc_wr;
   assign post_wr = cmd.do_single && (kind == eqps_pkg::REQ_POST) && tgt_ok &&
                    reg_ff[tgt] && (cnt_ff[tgt] < CW'(QUEUE_DEPTH));
   assign bc_wr   = cmd.do_sweep && (kind == eqps_pkg::REQ_BROADCAST) &&
                    (cnt_ff[cur] < CW'(QUEUE_DEPTH));

   // event memory
   always_ff @(posedge clock) begin
      if (post_wr) begin
         mem[wr_addr_s] <= new_ev;
      end else if (bc_wr) begin
         mem[wr_addr_b] <= new_ev;
      end
      if (cmd.do_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   logic [TW-1:0] deq_t_ff;
   always_ff @(posedge clock) begin
      if (cmd.do_read) begin
         deq_t_ff <= rd_t;
      end
   end

   // head of the dequeued target after the pop
   logic [QW-1:0] head_nx;
   assign head_nx = (head_ff[deq_t_ff] == QW'(QUEUE_DEPTH - 1)) ? '0 :
                    head_ff[deq_t_ff] + 1'b1;

   // queue state, flags and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff        <= '0;
         rdy_ff        <= '0;
         idx_ff        <= '0;
         emitted_ff    <= 1'b0;
         busy_sweep_ff <= 1'b0;
         for (int i = 0; i < TARGET_COUNT; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (cmd.clear_idx) begin
            idx_ff     <= '0;
            emitted_ff <= 1'b0;
         end else if (cmd.step_idx) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.do_read) busy_sweep_ff <= !single_op;
         if (cmd.do_sweep || (cmd.emit && busy_sweep_ff)) emitted_ff <= 1'b1;
         if (cmd.do_single) begin
            unique case (kind)
               eqps_pkg::REQ_REGISTER: begin
                  if (tgt_ok) begin
                     reg_ff[tgt]  <= 1'b1;
                     head_ff[tgt] <= '0;
                     cnt_ff[tgt]  <= '0;
                  end
               end
               eqps_pkg::REQ_POST: begin
                  if (tgt_ok && reg_ff[tgt]) begin
                     if (post_wr) cnt_ff[tgt] <= cnt_ff[tgt] + 1'b1;
                     if (mode_ff) rdy_ff[tgt] <= 1'b1;
                  end
               end
               eqps_pkg::REQ_SET_READY: begin
                  if (tgt_ok) rdy_ff[tgt] <= 1'b1;
               end
               eqps_pkg::REQ_SCHEDULE: begin
                  if (top_found) rdy_ff[top] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (bc_wr) cnt_ff[cur] <= cnt_ff[cur] + 1'b1;
         if (cmd.do_sweep && (kind == eqps_pkg::REQ_BROADCAST) && mode_ff) begin
            rdy_ff[cur] <= 1'b1;
         end
         if (cmd.do_read && single_op) begin
            rdy_ff[top] <= 1'b0;
         end
         if (cmd.emit) begin
            head_ff[deq_t_ff] <= head_nx;
            cnt_ff[deq_t_ff]  <= cnt_ff[deq_t_ff] - 1'b1;
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.do_single || cmd.do_sweep || cmd.emit || cmd.emit_idle) begin
         rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   // last word: a single dispatch, or no sweep hit left above the current target
   logic close_last;
   assign close_last = (cmd.do_sweep && !more_above) ||
                       (cmd.emit && (!busy_sweep_ff || !more_above));

   // sweep, dispatch and idle words
   eqps_pkg::rsp_word_type sweep_lw, disp_w, idle_w;
   always_comb begin
      sweep_lw             = sweep_w;
      sweep_lw.is_last     = close_last;
      disp_w               = '0;
      disp_w.result_kind   = eqps_pkg::K_DISPATCH;
      disp_w.out_target    = 3'(deq_t_ff);
      disp_w.out_signal    = rd_ff[EW-1 -: 8];
      disp_w.out_payload   = 32'(rd_ff[PAYLOAD_BITS-1:0]);
      disp_w.is_last       = close_last;
      idle_w               = '0;
      idle_w.result_kind   = eqps_pkg::K_IDLE;
      idle_w.is_last       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.do_single) begin
         rsp_data <= single_w;
      end else if (cmd.do_sweep) begin
         rsp_data <= sweep_lw;
      end else if (cmd.emit) begin
         rsp_data <= disp_w;
      end else if (cmd.emit_idle) begin
         rsp_data <= idle_w;
      end
   end

endmodule
`default_nettype wire

[rtl/eqps_checker.sv]
`default_nettype none
module eqps_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire eqps_pkg::rsp_word_type rsp_data
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // no new request taken right after one is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // never ready while a non-final result is pending
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_last |-> !req_ready)
      else $error("ready before final result");

endmodule

bind event_queue_priority_scheduler eqps_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
